/* design/dpb_pkg.sv */
// ----------------------------------------------------------------------------
// dpb_pkg
// shared widths, constants, register codes and control types for the depth
// pixel back-projection block
// ----------------------------------------------------------------------------
package dpb_pkg;

  // field widths
  localparam int DEPTH_W    = 16;
  localparam int COLOR_W    = 8;
  localparam int LABEL_W    = 8;
  localparam int PRIN_W     = 15;
  localparam int INVF_W     = 24;
  localparam int STRIDE_W   = 4;
  localparam int LIMIT_W    = 11;
  localparam int PX_W       = 16;
  localparam int PY_W       = 13;
  localparam int PZ_W       = 13;
  localparam int RGB_W      = 24;
  localparam int PIXPOS_W   = 10;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // fixed point: 5 fraction bits of position plus 24 of reciprocal focal
  localparam int FRAC_SHIFT = 29;
  localparam int POS_FRAC   = 5;

  // one phase counter per possible stride value
  localparam int MAX_STRIDE = 15;
  localparam int PHASE_W    = 4;

  localparam int DEF_MAX_COLUMNS = 1024;
  localparam int DEF_MAX_ROWS    = 1024;

  // register reset values
  localparam logic [PRIN_W-1:0]   RST_PRINCIPAL_X = 15'd10274;
  localparam logic [PRIN_W-1:0]   RST_PRINCIPAL_Y = 15'd7502;
  localparam logic [INVF_W-1:0]   RST_INV_FOCAL_X = 24'd68491;
  localparam logic [INVF_W-1:0]   RST_INV_FOCAL_Y = 24'd68491;
  localparam logic [STRIDE_W-1:0] RST_STRIDE      = 4'd4;
  localparam logic [LIMIT_W-1:0]  RST_VALID_ROWS  = 11'd384;
  localparam logic [LIMIT_W-1:0]  RST_ROW_WIDTH   = 11'd640;
  localparam logic [DEPTH_W-1:0]  RST_MAX_DEPTH   = 16'd6144;

  // acceptance limits
  localparam logic [LABEL_W-1:0]   LABEL_MAX = 8'd200;
  localparam logic signed [PX_W-1:0] Y_LOW   = -16'sd3072;
  localparam logic signed [PX_W-1:0] Y_HIGH  = 16'sd512;
  localparam logic [DEPTH_W-1:0]   Z_HIGH    = 16'd5120;
  localparam logic signed [PX_W-1:0] SAT_POS = 16'sd32767;
  localparam logic signed [PX_W-1:0] SAT_NEG = -16'sd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRINCIPAL_X = 3'd0,
    CFG_PRINCIPAL_Y = 3'd1,
    CFG_INV_FOCAL_X = 3'd2,
    CFG_INV_FOCAL_Y = 3'd3,
    CFG_STRIDE      = 3'd4,
    CFG_VALID_ROWS  = 3'd5,
    CFG_ROW_WIDTH   = 3'd6,
    CFG_MAX_DEPTH   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAG,
    ST_MUL_X,
    ST_MUL_XY,
    ST_MUL_Y,
    ST_EMIT
  } dpb_state_t;

  typedef struct packed {
    logic load_item;
    logic load_mag;
    logic mul_a_en;
    logic mul_a_sel_y;
    logic mul_b_en;
    logic mul_b_sel_y;
    logic take_x;
    logic load_out;
  } dpb_cmd_t;

  typedef struct packed {
    logic keep;
    logic y_ok;
    logic out_busy;
  } dpb_status_t;

endpackage

/* design/dpb_position.sv */
// ----------------------------------------------------------------------------
// dpb_position
// raster column and row counters with per-stride phase counters
// ----------------------------------------------------------------------------
module dpb_position #(
  parameter int MAX_COLUMNS = dpb_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = dpb_pkg::DEF_MAX_ROWS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          advance,
  input  logic                          frame_start,
  input  logic [dpb_pkg::STRIDE_W-1:0]  stride,
  input  logic [dpb_pkg::LIMIT_W-1:0]   row_width,
  output logic [$clog2(MAX_COLUMNS)-1:0] cur_col,
  output logic [$clog2(MAX_ROWS)-1:0]    cur_row,
  output logic                          col_hit,
  output logic                          row_hit
);
  import dpb_pkg::*;

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int MW    = (CW > RW) ? CW : RW;
  localparam int CMPW  = ((MW > LIMIT_W) ? MW : LIMIT_W) + 1;

  logic [CW-1:0]      col_r, col_nxt;
  logic [RW-1:0]      row_r, row_nxt;
  logic [PHASE_W-1:0] col_ph_r   [1:MAX_STRIDE];
  logic [PHASE_W-1:0] col_ph_nxt [1:MAX_STRIDE];
  logic [PHASE_W-1:0] row_ph_r   [1:MAX_STRIDE];
  logic [PHASE_W-1:0] row_ph_nxt [1:MAX_STRIDE];
  logic [PHASE_W-1:0] cur_cph    [1:MAX_STRIDE];
  logic [PHASE_W-1:0] cur_rph    [1:MAX_STRIDE];
  logic [CMPW-1:0]    col_inc, row_inc;
  logic               col_wrap, row_wrap;
  logic [STRIDE_W-1:0] stride_sel;

  assign cur_col  = frame_start ? '0 : col_r;
  assign cur_row  = frame_start ? '0 : row_r;
  assign col_inc  = CMPW'(cur_col) + CMPW'(1);
  assign row_inc  = CMPW'(cur_row) + CMPW'(1);
  assign col_wrap = (col_inc >= CMPW'(row_width)) || (col_inc >= CMPW'(MAX_COLUMNS));
  assign row_wrap = row_inc >= CMPW'(MAX_ROWS);

  assign col_nxt = col_wrap ? '0 : col_inc[CW-1:0];
  assign row_nxt = col_wrap ? (row_wrap ? '0 : row_inc[RW-1:0]) : cur_row;

  // phase k tracks position modulo k
  always_comb begin
    for (int k = 1; k <= MAX_STRIDE; k++) begin
      cur_cph[k] = frame_start ? '0 : col_ph_r[k];
      cur_rph[k] = frame_start ? '0 : row_ph_r[k];
      if (col_wrap) begin
        col_ph_nxt[k] = '0;
        if (row_wrap || cur_rph[k] == PHASE_W'(k - 1)) begin
          row_ph_nxt[k] = '0;
        end else begin
          row_ph_nxt[k] = cur_rph[k] + PHASE_W'(1);
        end
      end else begin
        col_ph_nxt[k] = (cur_cph[k] == PHASE_W'(k - 1)) ? '0 : cur_cph[k] + PHASE_W'(1);
        row_ph_nxt[k] = cur_rph[k];
      end
    end
  end

  // zero stride behaves as one
  assign stride_sel = (stride == '0) ? STRIDE_W'(1) : stride;
  assign col_hit    = cur_cph[stride_sel] == '0;
  assign row_hit    = cur_rph[stride_sel] == '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int k = 1; k <= MAX_STRIDE; k++) begin
        col_ph_r[k] <= '0;
        row_ph_r[k] <= '0;
      end
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      for (int k = 1; k <= MAX_STRIDE; k++) begin
        col_ph_r[k] <= col_ph_nxt[k];
        row_ph_r[k] <= row_ph_nxt[k];
      end
    end
  end

endmodule

/* design/dpb_datapath.sv */
// ----------------------------------------------------------------------------
// dpb_datapath
// pixel capture, offset magnitude, two-step shared multiply, saturation and
// the output register
// ----------------------------------------------------------------------------
module dpb_datapath #(
  parameter int MAX_COLUMNS = dpb_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = dpb_pkg::DEF_MAX_ROWS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dpb_pkg::dpb_cmd_t                cmd,
  output dpb_pkg::dpb_status_t             status,
  input  logic [dpb_pkg::DEPTH_W-1:0]      depth_q,
  input  logic [dpb_pkg::COLOR_W-1:0]      red,
  input  logic [dpb_pkg::COLOR_W-1:0]      green,
  input  logic [dpb_pkg::COLOR_W-1:0]      blue,
  input  logic [dpb_pkg::LABEL_W-1:0]      seg_label,
  input  logic [$clog2(MAX_COLUMNS)-1:0]   cur_col,
  input  logic [$clog2(MAX_ROWS)-1:0]      cur_row,
  input  logic                             col_hit,
  input  logic                             row_hit,
  input  logic [dpb_pkg::PRIN_W-1:0]       principal_x,
  input  logic [dpb_pkg::PRIN_W-1:0]       principal_y,
  input  logic [dpb_pkg::INVF_W-1:0]       inv_focal_x,
  input  logic [dpb_pkg::INVF_W-1:0]       inv_focal_y,
  input  logic [dpb_pkg::LIMIT_W-1:0]      valid_rows,
  input  logic [dpb_pkg::DEPTH_W-1:0]      depth_ceiling,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic signed [dpb_pkg::PX_W-1:0]  point_x,
  output logic signed [dpb_pkg::PY_W-1:0]  point_y,
  output logic [dpb_pkg::PZ_W-1:0]         point_z,
  output logic [dpb_pkg::RGB_W-1:0]        packed_rgb,
  output logic [dpb_pkg::LABEL_W-1:0]      point_label,
  output logic [dpb_pkg::PIXPOS_W-1:0]     pixel_col,
  output logic [dpb_pkg::PIXPOS_W-1:0]     pixel_row
);
  import dpb_pkg::*;

  localparam int CW    = $clog2(MAX_COLUMNS);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int MW    = (CW > RW) ? CW : RW;
  localparam int CMPW  = ((RW > LIMIT_W) ? RW : LIMIT_W) + 1;
  localparam int MAGW  = (MW + POS_FRAC > PRIN_W) ? MW + POS_FRAC : PRIN_W;
  localparam int PA_W  = MAGW + DEPTH_W;
  localparam int PB_W  = PA_W + INVF_W;
  localparam int QW    = PB_W - FRAC_SHIFT;

  // captured item
  logic [DEPTH_W-1:0] depth_r;
  logic [RGB_W-1:0]   rgb_r;
  logic [LABEL_W-1:0] label_r;
  logic [CW-1:0]      col_r;
  logic [RW-1:0]      row_r;
  logic               keep_r;
  logic               keep;

  // arithmetic
  logic [MAGW:0]      off_x, off_y;
  logic [MAGW-1:0]    mag_x_r, mag_y_r;
  logic               neg_x_r, neg_y_r;
  logic [PA_W-1:0]    prod_a_r;
  logic [PB_W-1:0]    prod_b_r;
  logic [QW-1:0]      quot;
  logic               neg_sel;
  logic signed [PX_W-1:0] sat;
  logic signed [PX_W-1:0] x_r;

  // output register
  logic                   out_valid_r;
  logic signed [PX_W-1:0] out_x_r;
  logic signed [PY_W-1:0] out_y_r;
  logic [PZ_W-1:0]        out_z_r;
  logic [RGB_W-1:0]       out_rgb_r;
  logic [LABEL_W-1:0]     out_label_r;
  logic [PIXPOS_W-1:0]    out_col_r, out_row_r;

  // every drop condition except the y bounds is known at capture
  assign keep = col_hit && row_hit && (CMPW'(cur_row) < CMPW'(valid_rows)) &&
                (depth_q != '0) && (depth_q < depth_ceiling) && (depth_q <= Z_HIGH) &&
                (seg_label != '0) && (seg_label <= LABEL_MAX);

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      depth_r <= depth_q;
      rgb_r   <= {red, green, blue};
      label_r <= seg_label;
      col_r   <= cur_col;
      row_r   <= cur_row;
      keep_r  <= keep;
    end
  end

  // signed offset pos*32 - principal, kept as sign and magnitude
  assign off_x = ((MAGW + 1)'(col_r) << POS_FRAC) - (MAGW + 1)'(principal_x);
  assign off_y = ((MAGW + 1)'(row_r) << POS_FRAC) - (MAGW + 1)'(principal_y);

  always_ff @(posedge clk) begin
    if (cmd.load_mag) begin
      neg_x_r <= off_x[MAGW];
      neg_y_r <= off_y[MAGW];
      mag_x_r <= off_x[MAGW] ? MAGW'(-off_x) : off_x[MAGW-1:0];
      mag_y_r <= off_y[MAGW] ? MAGW'(-off_y) : off_y[MAGW-1:0];
    end
  end

  // magnitude times depth, then times reciprocal focal
  always_ff @(posedge clk) begin
    if (cmd.mul_a_en) begin
      prod_a_r <= PA_W'(cmd.mul_a_sel_y ? mag_y_r : mag_x_r) * PA_W'(depth_r);
    end
    if (cmd.mul_b_en) begin
      prod_b_r <= PB_W'(prod_a_r) * PB_W'(cmd.mul_b_sel_y ? inv_focal_y : inv_focal_x);
    end
  end

  // truncate toward zero and saturate
  assign quot    = prod_b_r[PB_W-1:FRAC_SHIFT];
  assign neg_sel = cmd.take_x ? neg_x_r : neg_y_r;

  always_comb begin
    if (!neg_sel) begin
      sat = (quot > QW'(32767)) ? SAT_POS : PX_W'(quot);
    end else begin
      sat = (quot > QW'(32768)) ? SAT_NEG : -PX_W'(quot);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_x) begin
      x_r <= sat;
    end
  end

  assign status.keep     = keep_r;
  assign status.y_ok     = (sat >= Y_LOW) && (sat <= Y_HIGH);
  assign status.out_busy = out_valid_r && !out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_x_r     <= x_r;
      out_y_r     <= sat[PY_W-1:0];
      out_z_r     <= depth_r[PZ_W-1:0];
      out_rgb_r   <= rgb_r;
      out_label_r <= label_r;
      out_col_r   <= PIXPOS_W'(col_r);
      out_row_r   <= PIXPOS_W'(row_r);
    end
  end

  assign out_valid   = out_valid_r;
  assign point_x     = out_x_r;
  assign point_y     = out_y_r;
  assign point_z     = out_z_r;
  assign packed_rgb  = out_rgb_r;
  assign point_label = out_label_r;
  assign pixel_col   = out_col_r;
  assign pixel_row   = out_row_r;

endmodule

/* design/dpb_ctrl.sv */
// ----------------------------------------------------------------------------
// dpb_ctrl
// sequencer for one pixel: capture, offsets, shared multiply steps, emit
// ----------------------------------------------------------------------------
module dpb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  dpb_pkg::dpb_status_t status,
  output dpb_pkg::dpb_cmd_t    cmd
);
  import dpb_pkg::*;

  dpb_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_MAG;
      end
      ST_MAG: begin
        state_nxt = status.keep ? ST_MUL_X : ST_IDLE;
      end
      ST_MUL_X:  state_nxt = ST_MUL_XY;
      ST_MUL_XY: state_nxt = ST_MUL_Y;
      ST_MUL_Y:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!status.y_ok || !status.out_busy) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_item = in_valid;
      end
      ST_MAG: begin
        cmd.load_mag = 1'b1;
      end
      ST_MUL_X: begin
        cmd.mul_a_en = 1'b1;
      end
      ST_MUL_XY: begin
        cmd.mul_b_en    = 1'b1;
        cmd.mul_a_en    = 1'b1;
        cmd.mul_a_sel_y = 1'b1;
      end
      ST_MUL_Y: begin
        cmd.mul_b_en    = 1'b1;
        cmd.mul_b_sel_y = 1'b1;
        cmd.take_x      = 1'b1;
      end
      ST_EMIT: begin
        cmd.load_out = status.y_ok && !status.out_busy;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

/* design/depth_pixel_backprojection.sv */
// ----------------------------------------------------------------------------
// depth_pixel_backprojection
// back-projects sampled depth-map pixels into 3d points with color and label
// ----------------------------------------------------------------------------
// usage
//   in_*  : one depth pixel per beat in raster order, with color, label and
//           frame_start (this beat is row 0 column 0)
//   out_* : one point per kept pixel, x/y/z in 1/1024 m, packed rgb, label
//           and source position
//   cfg_* : register writes, always ready, to be sent only while no pixel
//           is in flight
// timing
//   a pixel dropped by stride, row, depth or label checks frees the input
//   after its offset step; any other pixel holds it through the offset step,
//   the shared two-step multiplier that serves x and then y, and its emit
//   step, where a point inside the y bounds is loaded into the output register
// stalls
//   the output register holds a point while out_ready is low; the next pixel
//   is still taken and worked on, and waits only at its own emit step
// reset
//   rst_n (synchronous) restores register defaults, zeroes the counters and
//   clears the output valid
// ----------------------------------------------------------------------------
module depth_pixel_backprojection #(
  parameter int MAX_COLUMNS = dpb_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = dpb_pkg::DEF_MAX_ROWS
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // pixel channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dpb_pkg::DEPTH_W-1:0]        in_depth_q,
  input  logic [dpb_pkg::COLOR_W-1:0]        in_red,
  input  logic [dpb_pkg::COLOR_W-1:0]        in_green,
  input  logic [dpb_pkg::COLOR_W-1:0]        in_blue,
  input  logic [dpb_pkg::LABEL_W-1:0]        in_seg_label,
  input  logic                               in_frame_start,
  // point channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [dpb_pkg::PX_W-1:0]    out_point_x,
  output logic signed [dpb_pkg::PY_W-1:0]    out_point_y,
  output logic [dpb_pkg::PZ_W-1:0]           out_point_z,
  output logic [dpb_pkg::RGB_W-1:0]          out_packed_rgb,
  output logic [dpb_pkg::LABEL_W-1:0]        out_point_label,
  output logic [dpb_pkg::PIXPOS_W-1:0]       out_pixel_col,
  output logic [dpb_pkg::PIXPOS_W-1:0]       out_pixel_row,
  // register write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dpb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dpb_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dpb_pkg::*;

  localparam int CW = $clog2(MAX_COLUMNS);
  localparam int RW = $clog2(MAX_ROWS);

  // configuration registers
  logic [PRIN_W-1:0]   principal_x_r, principal_y_r;
  logic [INVF_W-1:0]   inv_focal_x_r, inv_focal_y_r;
  logic [STRIDE_W-1:0] stride_r;
  logic [LIMIT_W-1:0]  valid_rows_r, row_width_r;
  logic [DEPTH_W-1:0]  depth_ceiling_r;

  dpb_cmd_t    cmd;
  dpb_status_t status;

  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic          col_hit, row_hit;

  // writes are never back-pressured
  assign cfg_ready = 1'b1;

  // each write keeps the low bits that fit the register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      principal_x_r   <= RST_PRINCIPAL_X;
      principal_y_r   <= RST_PRINCIPAL_Y;
      inv_focal_x_r   <= RST_INV_FOCAL_X;
      inv_focal_y_r   <= RST_INV_FOCAL_Y;
      stride_r        <= RST_STRIDE;
      valid_rows_r    <= RST_VALID_ROWS;
      row_width_r     <= RST_ROW_WIDTH;
      depth_ceiling_r <= RST_MAX_DEPTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_PRINCIPAL_X: principal_x_r   <= cfg_data[PRIN_W-1:0];
        CFG_PRINCIPAL_Y: principal_y_r   <= cfg_data[PRIN_W-1:0];
        CFG_INV_FOCAL_X: inv_focal_x_r   <= cfg_data[INVF_W-1:0];
        CFG_INV_FOCAL_Y: inv_focal_y_r   <= cfg_data[INVF_W-1:0];
        CFG_STRIDE:      stride_r        <= cfg_data[STRIDE_W-1:0];
        CFG_VALID_ROWS:  valid_rows_r    <= cfg_data[LIMIT_W-1:0];
        CFG_ROW_WIDTH:   row_width_r     <= cfg_data[LIMIT_W-1:0];
        CFG_MAX_DEPTH:   depth_ceiling_r <= cfg_data[DEPTH_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // raster position, advanced on every accepted pixel
  dpb_position #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_position (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (cmd.load_item),
    .frame_start (in_frame_start),
    .stride      (stride_r),
    .row_width   (row_width_r),
    .cur_col     (cur_col),
    .cur_row     (cur_row),
    .col_hit     (col_hit),
    .row_hit     (row_hit)
  );

  // per-pixel sequencer
  dpb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // arithmetic and output register
  dpb_datapath #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .status        (status),
    .depth_q       (in_depth_q),
    .red           (in_red),
    .green         (in_green),
    .blue          (in_blue),
    .seg_label     (in_seg_label),
    .cur_col       (cur_col),
    .cur_row       (cur_row),
    .col_hit       (col_hit),
    .row_hit       (row_hit),
    .principal_x   (principal_x_r),
    .principal_y   (principal_y_r),
    .inv_focal_x   (inv_focal_x_r),
    .inv_focal_y   (inv_focal_y_r),
    .valid_rows    (valid_rows_r),
    .depth_ceiling (depth_ceiling_r),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .point_x       (out_point_x),
    .point_y       (out_point_y),
    .point_z       (out_point_z),
    .packed_rgb    (out_packed_rgb),
    .point_label   (out_point_label),
    .pixel_col     (out_pixel_col),
    .pixel_row     (out_pixel_row)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// checks depth pixel back-projection: pixel beats go in under random gaps, a
// scoreboard predicts the emitted points and compares every output beat
// ----------------------------------------------------------------------------
module testbench;
  import dpb_pkg::*;

  localparam int RANDOM_BEATS = 370;
  localparam int DRAIN_CYCLES = 12;

  typedef struct packed {
    logic [DEPTH_W-1:0] depth;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [LABEL_W-1:0] label;
    logic               frame_start;
  } pixel_t;

  typedef struct packed {
    logic [PX_W-1:0]     x;
    logic [PY_W-1:0]     y;
    logic [PZ_W-1:0]     z;
    logic [RGB_W-1:0]    rgb;
    logic [LABEL_W-1:0]  label;
    logic [PIXPOS_W-1:0] col;
    logic [PIXPOS_W-1:0] row;
  } point_t;

  // predicts points from accepted pixels and holds them until they come out
  class point_tracker;
    logic [PRIN_W-1:0]   center_x, center_y;
    logic [INVF_W-1:0]   recip_fx, recip_fy;
    logic [STRIDE_W-1:0] stride;
    logic [LIMIT_W-1:0]  row_limit, row_width;
    logic [DEPTH_W-1:0]  depth_limit;
    int unsigned         col, row;
    point_t              pending_points[$];
    int                  mismatches;

    function new();
      center_x    = RST_PRINCIPAL_X;
      center_y    = RST_PRINCIPAL_Y;
      recip_fx    = RST_INV_FOCAL_X;
      recip_fy    = RST_INV_FOCAL_Y;
      stride      = RST_STRIDE;
      row_limit   = RST_VALID_ROWS;
      row_width   = RST_ROW_WIDTH;
      depth_limit = RST_MAX_DEPTH;
      col         = 0;
      row         = 0;
      mismatches  = 0;
    endfunction

    // bits above each register's width are dropped
    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_PRINCIPAL_X: center_x    = value[PRIN_W-1:0];
        CFG_PRINCIPAL_Y: center_y    = value[PRIN_W-1:0];
        CFG_INV_FOCAL_X: recip_fx    = value[INVF_W-1:0];
        CFG_INV_FOCAL_Y: recip_fy    = value[INVF_W-1:0];
        CFG_STRIDE:      stride      = value[STRIDE_W-1:0];
        CFG_VALID_ROWS:  row_limit   = value[LIMIT_W-1:0];
        CFG_ROW_WIDTH:   row_width   = value[LIMIT_W-1:0];
        CFG_MAX_DEPTH:   depth_limit = value[DEPTH_W-1:0];
        default: ;
      endcase
    endfunction

    // offset in 1/32 pixel times depth times Q0.24 reciprocal, truncated
    // toward zero back to 1/1024 m and saturated to 16 bits
    function int backproject(int unsigned pos, int unsigned center,
                             int unsigned depth, int unsigned recip);
      longint          offset;
      longint unsigned mag, q;
      offset = longint'(pos) * (1 << POS_FRAC) - longint'(center);
      mag    = (offset < 0) ? -offset : offset;
      q      = (mag * depth * recip) >> FRAC_SHIFT;
      if (offset >= 0) return (q > 32767) ? int'(SAT_POS) : int'(q);
      return (q > 32768) ? int'(SAT_NEG) : -int'(q);
    endfunction

    function void take_pixel(pixel_t p);
      int unsigned pitch;
      int          px, py;
      point_t      pt;
      if (p.frame_start) begin
        col = 0;
        row = 0;
      end
      pitch = (stride == 0) ? 1 : stride;
      if (col % pitch == 0 && row % pitch == 0 && row < row_limit &&
          p.depth != 0 && p.depth < depth_limit &&
          p.label != 0 && p.label <= LABEL_MAX) begin
        px = backproject(col, center_x, p.depth, recip_fx);
        py = backproject(row, center_y, p.depth, recip_fy);
        if (py >= int'(Y_LOW) && py <= int'(Y_HIGH) && p.depth <= Z_HIGH) begin
          pt.x     = px[PX_W-1:0];
          pt.y     = py[PY_W-1:0];
          pt.z     = p.depth[PZ_W-1:0];
          pt.rgb   = {p.red, p.green, p.blue};
          pt.label = p.label;
          pt.col   = col[PIXPOS_W-1:0];
          pt.row   = row[PIXPOS_W-1:0];
          pending_points.insert(pending_points.size(), pt);
        end
      end
      col++;
      if (col >= row_width || col >= DEF_MAX_COLUMNS) begin
        col = 0;
        row++;
        if (row >= DEF_MAX_ROWS) row = 0;
      end
    endfunction

    function void compare(string name, logic [RGB_W-1:0] want, logic [RGB_W-1:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_point(point_t got);
      point_t want;
      if (pending_points.size() == 0) begin
        $display("%0t: point mismatch, expected none, got x %0h y %0h z %0h col %0d row %0d",
                 $time, got.x, got.y, got.z, got.col, got.row);
        mismatches++;
        return;
      end
      want = pending_points.pop_front();
      compare("point_x", want.x, got.x);
      compare("point_y", want.y, got.y);
      compare("point_z", want.z, got.z);
      compare("packed_rgb", want.rgb, got.rgb);
      compare("point_label", want.label, got.label);
      compare("pixel_col", want.col, got.col);
      compare("pixel_row", want.row, got.row);
    endfunction
  endclass

  logic                  clk            = 1'b0;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [DEPTH_W-1:0]    in_depth_q     = '0;
  logic [COLOR_W-1:0]    in_red         = '0;
  logic [COLOR_W-1:0]    in_green       = '0;
  logic [COLOR_W-1:0]    in_blue        = '0;
  logic [LABEL_W-1:0]    in_seg_label   = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic signed [PX_W-1:0] out_point_x;
  logic signed [PY_W-1:0] out_point_y;
  logic [PZ_W-1:0]       out_point_z;
  logic [RGB_W-1:0]      out_packed_rgb;
  logic [LABEL_W-1:0]    out_point_label;
  logic [PIXPOS_W-1:0]   out_pixel_col;
  logic [PIXPOS_W-1:0]   out_pixel_row;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  point_tracker sb;
  bit           steady = 1'b0;   // no sender gaps during this stretch
  int           random_beats = 0;

  depth_pixel_backprojection u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_depth_q      (in_depth_q),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_seg_label    (in_seg_label),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_z     (out_point_z),
    .out_packed_rgb  (out_packed_rgb),
    .out_point_label (out_point_label),
    .out_pixel_col   (out_pixel_col),
    .out_pixel_row   (out_pixel_row),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case a beat never gets through
  initial begin
    #8_000_000;
    $display("FAILURE");
    $finish;
  end

  // output side: stretches of steady ready, short random stalls, long stalls
  initial begin
    int mode;
    forever begin
      mode = $urandom_range(0, 9);
      repeat ($urandom_range(10, 80)) begin
        @(negedge clk);
        if (mode < 3)      out_ready = 1'b1;
        else if (mode < 8) out_ready = ($urandom_range(0, 3) != 0);
        else               out_ready = ($urandom_range(0, 19) == 0);
      end
    end
  end

  // every accepted point beat goes straight to the scoreboard
  always @(posedge clk) begin : watch_points
    point_t got;
    if (rst_n && out_valid && out_ready) begin
      got.x     = out_point_x;
      got.y     = out_point_y;
      got.z     = out_point_z;
      got.rgb   = out_packed_rgb;
      got.label = out_point_label;
      got.col   = out_pixel_col;
      got.row   = out_pixel_row;
      sb.check_point(got);
    end
  end

  function automatic pixel_t make_pixel(logic [DEPTH_W-1:0] depth, logic [LABEL_W-1:0] label,
                                        bit frame_start, logic [RGB_W-1:0] rgb);
    pixel_t p;
    p.depth       = depth;
    p.label       = label;
    p.frame_start = frame_start;
    {p.red, p.green, p.blue} = rgb;
    return p;
  endfunction

  // mostly well-formed pixels inside the current depth limit, some raw noise
  function automatic pixel_t random_pixel(bit lead);
    pixel_t             p;
    logic [DEPTH_W-1:0] cap;
    cap = sb.depth_limit;
    p   = make_pixel(DEPTH_W'($urandom_range(1, (cap > 1) ? cap - 1 : 1)),
                     LABEL_W'($urandom_range(1, LABEL_MAX)), lead, RGB_W'($urandom));
    if ($urandom_range(0, 7) == 0) begin
      p.depth       = DEPTH_W'($urandom);
      p.label       = LABEL_W'($urandom);
      p.frame_start = lead | ($urandom_range(0, 7) == 0);
    end
    return p;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance;
  // valid stays high between back-to-back beats
  task automatic send_pixel(input pixel_t p);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    if (steady || roll < 55) gap = 0;
    else if (roll < 92)      gap = $urandom_range(1, 3);
    else                     gap = $urandom_range(6, 20);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_depth_q     = p.depth;
    in_red         = p.red;
    in_green       = p.green;
    in_blue        = p.blue;
    in_seg_label   = p.label;
    in_frame_start = p.frame_start;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.take_pixel(p);
    @(negedge clk);
  endtask

  // hold off the sender until every predicted point is out, then let any
  // dropped pixel still in flight finish
  task automatic drain_points();
    in_valid = 1'b0;
    while (sb.pending_points.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // now and then junk goes above the register's width to check masking
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value,
                           input int width);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    if ($urandom_range(0, 3) == 0) value = value | (junk << width);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, value);
    @(negedge clk);
  endtask

  task automatic load_settings(input int cx, cy, fx, fy, pitch, rows, width, dmax);
    write_reg(CFG_PRINCIPAL_X, CFG_DATA_W'(cx), PRIN_W);
    write_reg(CFG_PRINCIPAL_Y, CFG_DATA_W'(cy), PRIN_W);
    write_reg(CFG_INV_FOCAL_X, CFG_DATA_W'(fx), INVF_W);
    write_reg(CFG_INV_FOCAL_Y, CFG_DATA_W'(fy), INVF_W);
    write_reg(CFG_STRIDE, CFG_DATA_W'(pitch), STRIDE_W);
    write_reg(CFG_VALID_ROWS, CFG_DATA_W'(rows), LIMIT_W);
    write_reg(CFG_ROW_WIDTH, CFG_DATA_W'(width), LIMIT_W);
    write_reg(CFG_MAX_DEPTH, CFG_DATA_W'(dmax), DEPTH_W);
    cfg_valid = 1'b0;
  endtask

  // small image with matching optics, sometimes one or two registers at an
  // extreme, then a few frames of mostly well-formed raster pixels
  task automatic random_phase();
    int       cx, cy, fx, fy, pitch, rows, width, dmax;
    int       w, h, len;
    cfg_reg_t pick;
    w     = $urandom_range(1, 16);
    h     = $urandom_range(2, 16);
    width = w;
    rows  = $urandom_range(1, h + 2);
    pitch = $urandom_range(1, 4);
    cx    = $urandom_range(0, w * 32);
    cy    = $urandom_range(0, h * 32);
    fx    = $urandom_range(20000, 300000);
    fy    = $urandom_range(20000, 300000);
    dmax  = $urandom_range(800, 8000);
    repeat (2) begin
      pick = cfg_reg_t'($urandom_range(0, (1 << CFG_IDX_W) - 1));
      if ($urandom_range(0, 2) == 0) begin
        case (pick)
          CFG_PRINCIPAL_X: cx = $urandom_range(0, 1) ? 32767 : 0;
          CFG_PRINCIPAL_Y: cy = $urandom_range(0, 1) ? 32767 : 0;
          CFG_INV_FOCAL_X: fx = $urandom_range(0, 1) ? 16777215 : $urandom_range(0, 1);
          CFG_INV_FOCAL_Y: fy = $urandom_range(0, 1) ? 16777215 : $urandom_range(0, 1);
          CFG_STRIDE:      pitch = $urandom_range(0, 1) ? $urandom_range(8, 15) : 0;
          CFG_VALID_ROWS:  rows = $urandom_range(0, 1) ? 2047 : $urandom_range(0, 1);
          CFG_ROW_WIDTH:   width = $urandom_range(0, 1) ? $urandom_range(1024, 2047) : 0;
          CFG_MAX_DEPTH:   dmax = $urandom_range(0, 1) ? 65535 : $urandom_range(0, 1);
          default: ;
        endcase
      end
    end
    load_settings(cx, cy, fx, fy, pitch, rows, width, dmax);
    repeat ($urandom_range(2, 4)) begin
      steady = ($urandom_range(0, 3) == 0);
      len    = (w * h + $urandom_range(0, 4) > 120) ? 120 : w * h + $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) len = $urandom_range(1, len);
      for (int k = 0; k < len && random_beats < RANDOM_BEATS; k++) begin
        send_pixel(random_pixel(k == 0));
        random_beats++;
        // sender waits mid-frame for the output side to catch up
        if (k == len / 2 && $urandom_range(0, 5) == 0) drain_points();
      end
    end
    drain_points();
  endtask

  initial begin
    sb = new();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: depth, label and z limits, then a stride skip on row 0
    send_pixel(make_pixel(16'd1, 8'd1, 1'b1, 24'h000000));
    send_pixel(make_pixel(16'd5120, LABEL_MAX, 1'b1, 24'hffffff));
    send_pixel(make_pixel(RST_MAX_DEPTH - 16'd1, 8'd1, 1'b1, 24'h0055aa));
    send_pixel(make_pixel(RST_MAX_DEPTH, 8'd7, 1'b1, 24'haa5500));
    send_pixel(make_pixel(16'd0, 8'd50, 1'b1, RGB_W'($urandom)));
    send_pixel(make_pixel(16'hffff, 8'd50, 1'b1, RGB_W'($urandom)));
    send_pixel(make_pixel(16'd1000, 8'd0, 1'b1, RGB_W'($urandom)));
    send_pixel(make_pixel(16'd1000, LABEL_MAX + 8'd1, 1'b1, RGB_W'($urandom)));
    send_pixel(make_pixel(16'd2000, 8'd100, 1'b1, RGB_W'($urandom)));
    repeat (4) send_pixel(make_pixel(16'd2000, 8'd100, 1'b0, RGB_W'($urandom)));
    drain_points();

    // principal point at the origin, unit focal, zero stride, two valid rows:
    // positive x saturates, z above the bound, full-scale depth dropped
    load_settings(0, 0, 16777215, 16777215, 0, 2, 8, 65535);
    send_pixel(make_pixel(16'd1, 8'd1, 1'b1, RGB_W'($urandom)));
    send_pixel(make_pixel(16'd5120, 8'd200, 1'b0, RGB_W'($urandom)));
    send_pixel(make_pixel(16'hffff, 8'd3, 1'b0, RGB_W'($urandom)));
    send_pixel(make_pixel(16'd5121, 8'd4, 1'b0, RGB_W'($urandom)));
    send_pixel(make_pixel(16'd300, 8'd5, 1'b0, RGB_W'($urandom)));
    send_pixel(make_pixel(16'd20, 8'd6, 1'b0, RGB_W'($urandom)));
    send_pixel(make_pixel(16'd4000, 8'd7, 1'b0, RGB_W'($urandom)));
    send_pixel(make_pixel(16'd5120, 8'd8, 1'b0, RGB_W'($urandom)));
    send_pixel(make_pixel(16'd300, 8'd9, 1'b0, RGB_W'($urandom)));
    send_pixel(make_pixel(16'd5, 8'd10, 1'b0, RGB_W'($urandom)));
    drain_points();

    // far principal point with negative x saturation, zero vertical
    // reciprocal, stride eight on a nine-pixel row
    load_settings(32767, 32767, 16777215, 0, 8, 2047, 9, 6000);
    for (int k = 0; k < 10; k++)
      send_pixel(make_pixel(DEPTH_W'($urandom_range(1000, 5000)),
                            LABEL_W'($urandom_range(1, LABEL_MAX)),
                            k == 0, RGB_W'($urandom)));
    drain_points();

    while (random_beats < RANDOM_BEATS) random_phase();

    drain_points();
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
